// ===== src/argtok_pkg.sv =====
// Package for the argument tokenizer: status codes, record kinds, character constants
// and the queued result entry type. No dependencies.
package argtok_pkg;

  localparam int MaxTextDefault   = 256;
  localparam int MaxTokensDefault = 16;

  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] TabChar   = 8'h09;
  localparam logic [7:0] PrintLo   = 8'h20;
  localparam logic [7:0] PrintHi   = 8'h7E;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_BAD_BYTE = 2'd3
  } status_e;

  typedef enum logic {
    KIND_TOKEN  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // Everything one request produces: an optional token record and an optional status record.
  typedef struct packed {
    logic       tok_valid;
    logic [3:0] tok_index;
    logic [7:0] tok_offset;
    logic [8:0] tok_length;
    logic [4:0] tok_total;
    logic       stat_valid;
    status_e    stat_status;
    logic [4:0] stat_total;
  } result_t;

endpackage

// ===== src/argument_tokenizer.sv =====
// Argument tokenizer top level: byte-serial whitespace splitter with a two-entry result queue.
// Depends on argtok_pkg.
//
//   channel | handshake                  | payload
//   --------+----------------------------+---------------------------------------------------
//   in      | in_valid_i / in_ready_o    | text_byte_i, byte_present_i, end_of_text_i
//   out     | out_valid_o / out_ready_i  | record_kind_o, token_index_o, token_offset_o,
//           |                            | token_length_o, parse_status_o, token_total_o,
//           |                            | last_record_o
//
// One request is taken per cycle while in_ready_o is high. Its whole effect on the
// scan state is computed in the cycle it is accepted, and its records land in the
// result queue on the same edge; they show on the output once their entry is the head.
// A request that yields both a token and a status record presents the token first and
// then the status record; one that yields nothing never touches the queue.
// Input ready drops only while both queue entries are occupied; reset needs no sweep.
module argument_tokenizer
  import argtok_pkg::*;
#(
  parameter int MAX_TEXT   = MaxTextDefault,
  parameter int MAX_TOKENS = MaxTokensDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       record_kind_o,
  output logic [3:0] token_index_o,
  output logic [7:0] token_offset_o,
  output logic [8:0] token_length_o,
  output logic [1:0] parse_status_o,
  output logic [4:0] token_total_o,
  output logic       last_record_o
);

  // The position counter must hold MAX_TEXT + 1, the saturated "too long" value.
  localparam int PosW = $clog2(MAX_TEXT + 2);
  // The token counter must hold MAX_TOKENS itself.
  localparam int CntW = $clog2(MAX_TOKENS + 1);

  // Scan state.
  logic [PosW-1:0] pos_q, pos_d;
  logic            inside_q, inside_d;
  logic [PosW-1:0] start_q, start_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  status_e         err_q, err_d;

  logic            accept;
  logic            is_sep;
  logic            printable;
  logic            in_range;
  logic            too_long;
  result_t         ent;

  assign accept    = in_valid_i && in_ready_o;
  assign is_sep    = (text_byte_i == SpaceChar) || (text_byte_i == TabChar);
  assign printable = (text_byte_i >= PrintLo) && (text_byte_i <= PrintHi);
  assign in_range  = pos_q < PosW'(MAX_TEXT);

  // Next scan state and the records this request produces.
  always_comb begin
    pos_d    = pos_q;
    inside_d = inside_q;
    start_d  = start_q;
    cnt_d    = cnt_q;
    err_d    = err_q;
    ent      = '0;
    too_long = 1'b0;

    if (byte_present_i) begin
      if (in_range) begin
        if (err_q == ST_OK) begin
          if (is_sep) begin
            // A separator closes an open token.
            if (inside_q) begin
              ent.tok_valid  = 1'b1;
              ent.tok_index  = 4'(cnt_q);
              ent.tok_offset = 8'(start_q);
              ent.tok_length = 9'(pos_q - start_q);
              ent.tok_total  = 5'(cnt_q + 1'b1);
              cnt_d          = cnt_q + 1'b1;
              inside_d       = 1'b0;
            end
          end else begin
            // The token limit is checked before the byte itself is checked.
            if (!inside_q) begin
              if (cnt_q >= CntW'(MAX_TOKENS)) begin
                err_d = ST_TOO_MANY;
              end else begin
                inside_d = 1'b1;
                start_d  = pos_q;
              end
            end
            if ((err_d == ST_OK) && !printable) begin
              err_d    = ST_BAD_BYTE;
              inside_d = 1'b0;
            end
          end
        end
        pos_d = pos_q + 1'b1;
      end else begin
        // Bytes past the limit are only counted, and the count saturates.
        pos_d = PosW'(MAX_TEXT + 1);
      end
    end

    if (end_of_text_i) begin
      too_long = pos_d > PosW'(MAX_TEXT);
      // A token still open at the end of the string closes here, unless an error hit.
      if (inside_d && (err_d == ST_OK) && !too_long) begin
        ent.tok_valid  = 1'b1;
        ent.tok_index  = 4'(cnt_d);
        ent.tok_offset = 8'(start_d);
        ent.tok_length = 9'(pos_d - start_d);
        ent.tok_total  = 5'(cnt_d + 1'b1);
        cnt_d          = cnt_d + 1'b1;
      end
      ent.stat_valid  = 1'b1;
      ent.stat_status = too_long ? ST_TOO_LONG : err_d;
      ent.stat_total  = 5'(cnt_d);
      // The next string starts from a clean state.
      pos_d    = '0;
      inside_d = 1'b0;
      start_d  = '0;
      cnt_d    = '0;
      err_d    = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      inside_q <= 1'b0;
      start_q  <= '0;
      cnt_q    <= '0;
      err_q    <= ST_OK;
    end else if (accept) begin
      pos_q    <= pos_d;
      inside_q <= inside_d;
      start_q  <= start_d;
      cnt_q    <= cnt_d;
      err_q    <= err_d;
    end
  end

  // Result queue: two entries, each holding all records of one request. A head entry
  // with both records shows the token first (half_q low) and then the status record.
  result_t     q_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  fill_q, fill_d;
  logic        half_q, half_d;
  logic        push, pop;
  logic        show_tok;
  result_t     head;

  assign in_ready_o  = fill_q != 2'd2;
  assign out_valid_o = fill_q != 2'd0;
  assign push        = accept && (ent.tok_valid || ent.stat_valid);
  assign head        = q_q[rd_ptr_q];
  assign show_tok    = head.tok_valid && !half_q;
  assign pop         = out_valid_o && out_ready_i && (!show_tok || !head.stat_valid);

  always_comb begin
    fill_d = fill_q;
    unique case ({push, pop})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
    half_d = half_q;
    if (pop) begin
      half_d = 1'b0;
    end else if (out_valid_o && out_ready_i && show_tok) begin
      half_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
      half_q   <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_d;
      half_q <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= ent;
    end
  end

  // Output fields: the token record or the status record of the head entry.
  always_comb begin
    if (show_tok) begin
      record_kind_o  = KIND_TOKEN;
      token_index_o  = head.tok_index;
      token_offset_o = head.tok_offset;
      token_length_o = head.tok_length;
      parse_status_o = ST_OK;
      token_total_o  = head.tok_total;
      last_record_o  = 1'b0;
    end else begin
      record_kind_o  = KIND_STATUS;
      token_index_o  = '0;
      token_offset_o = '0;
      token_length_o = '0;
      parse_status_o = head.stat_status;
      token_total_o  = head.stat_total;
      last_record_o  = 1'b1;
    end
  end

endmodule

// ===== src/argtok_checker.sv =====
// Port-level checker for the argument tokenizer, bound to its top level.
// Depends on argtok_pkg and argument_tokenizer.
module argtok_checker
  import argtok_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       record_kind_o,
  input logic [3:0] token_index_o,
  input logic [7:0] token_offset_o,
  input logic [8:0] token_length_o,
  input logic [1:0] parse_status_o,
  input logic [4:0] token_total_o,
  input logic       last_record_o
);

  // A stalled result request keeps its record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(record_kind_o)
      && $stable(token_total_o) && $stable(parse_status_o))
    else $error("stalled result changed");

  // With nothing queued the input side can never be blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result queue");

  // Token records carry no status and never close the string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (record_kind_o == KIND_TOKEN) |->
      (parse_status_o == ST_OK) && !last_record_o)
    else $error("token record with status or end mark");

  // Status records close the string and carry no token position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (record_kind_o == KIND_STATUS) |->
      last_record_o && (token_index_o == 4'd0) && (token_offset_o == 8'd0)
      && (token_length_o == 9'd0))
    else $error("malformed status record");

endmodule

bind argument_tokenizer argtok_checker u_argtok_checker (.*);
